// File: rtl/sbct_pkg.sv
// Shared types and constants for the swept box collision time block.
package sbct_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAG_BITS  = 8;

  localparam int COORD_W = 32;
  localparam int HALF_W  = 31;
  localparam int TIME_W  = FRAC_BITS + 1;
  localparam int OFFS_W  = 16;
  localparam int FACE_W  = 3;
  localparam int TAGF_W  = 8;
  localparam int NUM_W   = 33;
  localparam int NFACES  = 6;

  localparam logic [0:0] REG_START_LIMIT = 1'b0;
  localparam logic [0:0] REG_MIN_OFFSET  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
    logic signed [COORD_W-1:0] move_x;
    logic signed [COORD_W-1:0] move_y;
    logic signed [COORD_W-1:0] move_z;
    logic [HALF_W-1:0]         half_x;
    logic [HALF_W-1:0]         half_y;
    logic [HALF_W-1:0]         half_z;
    logic [TAGF_W-1:0]         target_tag;
    logic                      start_query;
    logic                      last_pair;
  } pair_t;

  typedef struct packed {
    logic              any_hit;
    logic [TIME_W-1:0] hit_time;
    logic [FACE_W-1:0] hit_face;
    logic [TAGF_W-1:0] hit_tag;
  } result_t;

endpackage

// File: rtl/sbct_if.sv
// Valid/ready channel interfaces for pairs and results.
interface sbct_pair_if;
  import sbct_pkg::*;
  logic  valid;
  logic  ready;
  pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbct_result_if;
  import sbct_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sbct_front.sv
// Input stage and two-entry queue decoupling intake from face evaluation.
module sbct_front (
  input  logic            clk,
  input  logic            rst,
  sbct_pair_if.sink       in_ch,
  output sbct_pkg::pair_t q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  import sbct_pkg::*;

  pair_t     mem [2];
  logic      wptr, rptr;
  logic [1:0] count;
  logic      push;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign q_data      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_ch.data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// File: rtl/sbct_div.sv
// Restoring divider: quotient of (num << FRAC_BITS) / den, saturated at one.
module sbct_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sbct_pkg::NUM_W-1:0]    num,
  input  logic [sbct_pkg::NUM_W-1:0]    den,
  output logic                          done,
  output logic [sbct_pkg::TIME_W-1:0]   quot
);
  import sbct_pkg::*;

  localparam int STEPS = NUM_W + FRAC_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [STEPS-1:0] dvd;
  logic [NUM_W:0]   rem;
  logic [STEPS-1:0] q;
  logic [NUM_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [NUM_W:0]   trial;
  logic [NUM_W:0]   diff;

  assign trial = {rem[NUM_W-1:0], dvd[STEPS-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= {num, {FRAC_BITS{1'b0}}};
        dsr  <= den;
        rem  <= '0;
        q    <= '0;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        dvd <= dvd << 1;
        if (!diff[NUM_W]) begin
          rem <= diff;
          q   <= {q[STEPS-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[STEPS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = (q > STEPS'(1 << FRAC_BITS)) ? TIME_W'(1 << FRAC_BITS)
                                             : q[FRAC_BITS:0];
endmodule

// File: rtl/sbct_back.sv
// Face sequencer: per face divide, span check and best time update.
module sbct_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sbct_pkg::pair_t             q_data,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic [sbct_pkg::TIME_W-1:0] start_limit,
  input  logic [sbct_pkg::OFFS_W-1:0] min_offset,
  sbct_result_if.source               out_ch
);
  import sbct_pkg::*;

  localparam int TW = FRAC_BITS + 1;
  localparam int PW = COORD_W + FRAC_BITS + 3;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_DIV, S_SPAN, S_CHECK, S_NEXT, S_OUT
  } state_t;

  state_t            state;
  logic [2:0]        face;
  logic [TW-1:0]     best_time;
  logic              hit_seen;
  logic [FACE_W-1:0] best_face;
  logic [TAG_BITS-1:0] best_tag;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_num, div_den;
  logic [TW-1:0]     div_q;
  logic [TW-1:0]     t;
  logic signed [PW-1:0] pa, pb, ha, hb;
  logic              span_ok;

  logic signed [COORD_W-1:0] rel, dl, ra, ma, rb, mb;
  logic [HALF_W-1:0]         hd, hha, hhb;
  logic signed [NUM_W:0]     num_s;

  always_comb begin
    unique case (face[2:1])
      2'd0: begin
        rel = q_data.rel_x; dl = q_data.move_x; hd = q_data.half_x;
        ra = q_data.rel_y; ma = q_data.move_y; hha = q_data.half_y;
        rb = q_data.rel_z; mb = q_data.move_z; hhb = q_data.half_z;
      end
      2'd1: begin
        rel = q_data.rel_y; dl = q_data.move_y; hd = q_data.half_y;
        ra = q_data.rel_x; ma = q_data.move_x; hha = q_data.half_x;
        rb = q_data.rel_z; mb = q_data.move_z; hhb = q_data.half_z;
      end
      default: begin
        rel = q_data.rel_z; dl = q_data.move_z; hd = q_data.half_z;
        ra = q_data.rel_x; ma = q_data.move_x; hha = q_data.half_x;
        rb = q_data.rel_y; mb = q_data.move_y; hhb = q_data.half_y;
      end
    endcase
    if (face[0]) num_s = $signed({2'b0, hd}) - (NUM_W+1)'(rel);
    else         num_s = -$signed({2'b0, hd}) - (NUM_W+1)'(rel);
  end

  sbct_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  always_comb begin
    span_ok = (pa >= -ha) && (pa <= ha) && (pb >= -hb) && (pb <= hb);
  end

  assign q_pop = (state == S_NEXT) && (face == 3'd5) && !q_data.last_pair
               || (state == S_OUT) && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      face      <= '0;
      best_time <= TW'(1 << FRAC_BITS);
      hit_seen  <= 1'b0;
      best_face <= '0;
      best_tag  <= '0;
      div_start <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            face <= '0;
            if (q_data.start_query) begin
              best_time <= (start_limit > TIME_W'(1 << FRAC_BITS))
                         ? TW'(1 << FRAC_BITS) : TW'(start_limit);
              hit_seen  <= 1'b0;
              best_face <= '0;
              best_tag  <= '0;
            end
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          div_num <= num_s[NUM_W] ? NUM_W'(-num_s) : num_s[NUM_W-1:0];
          div_den <= dl[COORD_W-1] ? NUM_W'(-$signed({dl[COORD_W-1], dl}))
                                   : NUM_W'({1'b0, dl});
          if ((dl != 0) && ((num_s == 0) || (num_s[NUM_W] == dl[COORD_W-1]))) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_NEXT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t     <= div_q;
            state <= (div_q < best_time) ? S_SPAN : S_NEXT;
          end
        end
        S_SPAN: begin
          pa <= (PW'(ra) <<< FRAC_BITS) + $signed({1'b0, t}) * PW'(ma);
          pb <= (PW'(rb) <<< FRAC_BITS) + $signed({1'b0, t}) * PW'(mb);
          ha <= $signed(PW'({1'b0, hha})) <<< FRAC_BITS;
          hb <= $signed(PW'({1'b0, hhb})) <<< FRAC_BITS;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (span_ok) begin
            best_time <= (t > TW'(min_offset)) ? t - TW'(min_offset) : '0;
            hit_seen  <= 1'b1;
            best_face <= face;
            best_tag  <= q_data.target_tag[TAG_BITS-1:0];
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (face == 3'd5) begin
            if (q_data.last_pair) begin
              out_ch.valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            face  <= face + 1'b1;
            state <= S_SETUP;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_ch.data.any_hit  = hit_seen;
    out_ch.data.hit_time = TIME_W'(best_time);
    out_ch.data.hit_face = hit_seen ? best_face : '0;
    out_ch.data.hit_tag  = hit_seen ? TAGF_W'(best_tag) : '0;
  end
endmodule

// File: rtl/swept_box_collision_time.sv
// Top level of the swept box collision time block.
// Usage:
//   pair_in carries one mover/target pair per transfer; result_out carries
//   one query result for every pair flagged last_pair.
//   Config: cfg_we with cfg_index 0 (start_limit) or 1 (min_offset), written
//   only while idle.
//   A two-entry queue takes pairs while the face sequencer works.
//   Each pair is handled face by face: a face runs the one-bit-per-cycle
//   divider of 49 steps and then the span check, skips the span check when
//   its time does not beat the best, and skips both with zero move or wrong
//   sign. One pair at a time.
//   The result is valid the cycle after the last pair's sixth face; that
//   pair then holds the sequencer until the result transfers.
//   Reset clears the queue, best time to one, hit state and tag to zero,
//   and the registers to their defaults.
//   A stalled receiver holds the result; the queue fills, then pair_in
//   drops ready.
module swept_box_collision_time (
  input  logic                             clk,
  input  logic                             rst,
  sbct_pair_if.sink                        pair_in,
  sbct_result_if.source                    result_out,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [sbct_pkg::TIME_W-1:0]      cfg_data
);
  import sbct_pkg::*;

  pair_t             q_data;
  logic              q_valid, q_pop;
  logic [TIME_W-1:0] start_limit;
  logic [OFFS_W-1:0] min_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_limit <= TIME_W'(65536);
      min_offset  <= OFFS_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_LIMIT: start_limit <= cfg_data;
        REG_MIN_OFFSET:  min_offset  <= cfg_data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  sbct_front u_front (
    .clk(clk), .rst(rst), .in_ch(pair_in),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  sbct_back u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .start_limit(start_limit), .min_offset(min_offset), .out_ch(result_out)
  );

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_time_bound: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.data.hit_time <= TIME_W'(65536))
    else $error("hit time above one");
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.data.hit_face <= FACE_W'(5))
    else $error("face out of range");
endmodule
